// File: hw/rtl/kruskal_pkg.sv
// Shared types and constants for the Kruskal union-find block
`default_nettype none
package kruskal_pkg;

  // Node space and field widths
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NC_W      = 11;
  localparam int N_W       = (NODE_W + 1 > NC_W) ? NODE_W + 1 : NC_W;
  localparam int W_W       = 16;
  localparam int WT_W      = 26;
  localparam int TAG_W     = 8;
  localparam int ENT_W     = TAG_W + NODE_W;

  localparam logic [WT_W-1:0] WEIGHT_MAX = {WT_W{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_JOIN,
    ST_RESULT
  } state_t;

  // Result beat from the sequencer to the output register
  typedef struct packed {
    logic            valid;
    logic            taken;
    logic            complete;
    logic [WT_W-1:0] weight;
    logic            graph_end;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/kruskal_ram.sv
// Generic single-port synchronous RAM with registered read data
`default_nettype none
module kruskal_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/kruskal_ctrl.sv
// Union-find sequencer: root walks, path compression, union and totals
`default_nettype none
module kruskal_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [kruskal_pkg::N_W-1:0]   node_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kruskal_pkg::NC_W-1:0]  edge_from,
  input  wire logic [kruskal_pkg::NC_W-1:0]  edge_to,
  input  wire logic [kruskal_pkg::W_W-1:0]   edge_weight,
  input  wire logic                          last_edge,
  input  wire logic                          res_ready,
  output kruskal_pkg::res_t                  res
);
  import kruskal_pkg::*;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] sweep_r, sweep_nxt;
  logic [TAG_W-1:0]  epoch_r, epoch_nxt;
  logic [NODE_W-1:0] from_r, from_nxt;
  logic [NODE_W-1:0] to_r, to_nxt;
  logic [W_W-1:0]    w_r, w_nxt;
  logic              last_r, last_nxt;
  logic              side_r, side_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] root_r, root_nxt;
  logic [NODE_W-1:0] root_a_r, root_a_nxt;
  logic              taken_r, taken_nxt;
  logic [NODE_W-1:0] count_r, count_nxt;
  logic [WT_W-1:0]   total_r, total_nxt;
  logic              done_r, done_nxt;

  logic              ram_we;
  logic [NODE_W-1:0] ram_addr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic [NODE_W-1:0] ent_parent;

  logic [N_W-1:0]    from_ext, to_ext;
  logic [N_W-1:0]    count_p1;
  logic              pre_done;
  logic              ends_ok;
  logic              complete;
  logic [WT_W:0]     sum;

  kruskal_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Entry with a stale tag reads as its own root
  assign ent_parent = (ram_rdata[ENT_W-1 -: TAG_W] == epoch_r) ?
                      ram_rdata[NODE_W-1:0] : cur_r;

  assign from_ext = N_W'(edge_from);
  assign to_ext   = N_W'(edge_to);
  assign count_p1 = N_W'(count_r) + N_W'(1);
  assign pre_done = done_r | (count_p1 >= node_n);
  assign ends_ok  = (from_ext != '0) && (from_ext <= node_n) &&
                    (to_ext != '0) && (to_ext <= node_n);
  assign complete = done_r | (count_p1 >= node_n);
  assign sum      = {1'b0, total_r} + (WT_W+1)'(w_r);

  // Hold state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      sweep_r <= '0;
      epoch_r <= '0;
      count_r <= '0;
      total_r <= '0;
      done_r  <= 1'b0;
      taken_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      epoch_r <= epoch_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r   <= from_nxt;
    to_r     <= to_nxt;
    w_r      <= w_nxt;
    last_r   <= last_nxt;
    side_r   <= side_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    root_a_r <= root_a_nxt;
  end

  // Next state, memory port and result
  always_comb begin
    state_nxt  = state_r;
    sweep_nxt  = sweep_r;
    epoch_nxt  = epoch_r;
    from_nxt   = from_r;
    to_nxt     = to_r;
    w_nxt      = w_r;
    last_nxt   = last_r;
    side_nxt   = side_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    root_a_nxt = root_a_r;
    taken_nxt  = taken_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    done_nxt   = done_r;
    ram_we     = 1'b0;
    ram_addr   = cur_r;
    ram_wdata  = {epoch_r, root_r};
    in_stall   = 1'b1;
    res        = '0;

    case (state_r)
      // Write identity into every entry
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = {epoch_r, sweep_r};
        sweep_nxt = sweep_r + NODE_W'(1);
        if (sweep_r == {NODE_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take an edge beat
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          from_nxt  = NODE_W'(from_ext - N_W'(1));
          to_nxt    = NODE_W'(to_ext - N_W'(1));
          w_nxt     = edge_weight;
          last_nxt  = last_edge;
          done_nxt  = pre_done;
          taken_nxt = 1'b0;
          side_nxt  = 1'b0;
          cur_nxt   = NODE_W'(from_ext - N_W'(1));
          if (!pre_done && ends_ok) begin
            state_nxt = ST_FIND_RD;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end

      // Issue the first read of a root walk
      ST_FIND_RD: begin
        ram_addr  = cur_r;
        state_nxt = ST_FIND_CHK;
      end

      // Follow parent pointers, one read per cycle
      ST_FIND_CHK: begin
        if (ent_parent == cur_r) begin
          root_nxt  = cur_r;
          cur_nxt   = side_r ? to_r : from_r;
          state_nxt = ST_CMP_RD;
        end else begin
          ram_addr = ent_parent;
          cur_nxt  = ent_parent;
        end
      end

      // Walk the path again, pointing each node at the root
      ST_CMP_RD: begin
        ram_addr = cur_r;
        if (cur_r == root_r) begin
          if (!side_r) begin
            root_a_nxt = root_r;
            side_nxt   = 1'b1;
            cur_nxt    = to_r;
            state_nxt  = ST_FIND_RD;
          end else begin
            state_nxt = ST_JOIN;
          end
        end else begin
          state_nxt = ST_CMP_WR;
        end
      end

      ST_CMP_WR: begin
        ram_we    = 1'b1;
        ram_addr  = cur_r;
        ram_wdata = {epoch_r, root_r};
        cur_nxt   = ent_parent;
        state_nxt = ST_CMP_RD;
      end

      // Join the two sets if the roots differ
      ST_JOIN: begin
        if (root_a_r != root_r) begin
          ram_we    = 1'b1;
          ram_addr  = root_r;
          ram_wdata = {epoch_r, root_a_r};
          taken_nxt = 1'b1;
          count_nxt = count_r + NODE_W'(1);
          total_nxt = sum[WT_W] ? WEIGHT_MAX : sum[WT_W-1:0];
        end
        state_nxt = ST_RESULT;
      end

      // Hand the result to the output register
      ST_RESULT: begin
        res.valid     = 1'b1;
        res.taken     = taken_r;
        res.complete  = complete;
        res.weight    = (last_r && !complete) ? '0 : total_r;
        res.graph_end = last_r;
        if (res_ready) begin
          if (last_r) begin
            count_nxt = '0;
            total_nxt = '0;
            done_nxt  = 1'b0;
            epoch_nxt = epoch_r + TAG_W'(1);
            if (epoch_r == {TAG_W{1'b1}}) begin
              sweep_nxt = '0;
              state_nxt = ST_SWEEP;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            done_nxt  = complete;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/kruskal_union_find_mst.sv
// Top level: configuration register, union-find sequencer, output register
//
//   channel | handshake             | payload ports
//   in      | in_valid / in_stall   | in_edge_from, in_edge_to, in_edge_weight, in_last_edge
//   out     | out_valid / out_stall | out_edge_taken, out_tree_complete, out_tree_weight,
//           |                       | out_graph_end
//   cfg     | cfg_valid / cfg_ready | cfg_node_count
//
// A skipped edge (end out of range, tree already complete) goes straight to the result; a checked
// edge walks from each end to its root and back along the same path, with the single RAM port
// reading one pointer and rewriting one per step.
// After reset, and after every 256th graph, a pass rewrites every entry of the parent
// memory; no edge beat is taken meanwhile. Reset is synchronous, active low.
// A stalled result sits in the output register while the next edge is taken.
`default_nettype none
module kruskal_union_find_mst (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kruskal_pkg::NC_W-1:0]  in_edge_from,
  input  wire logic [kruskal_pkg::NC_W-1:0]  in_edge_to,
  input  wire logic [kruskal_pkg::W_W-1:0]   in_edge_weight,
  input  wire logic                          in_last_edge,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_edge_taken,
  output logic                               out_tree_complete,
  output logic [kruskal_pkg::WT_W-1:0]       out_tree_weight,
  output logic                               out_graph_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kruskal_pkg::NC_W-1:0]  cfg_node_count
);
  import kruskal_pkg::*;

  logic [NC_W-1:0] nc_r, nc_nxt;
  logic [N_W-1:0]  node_n;
  logic [N_W-1:0]  nc_ext;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_r, out_nxt;
  res_t            res;
  logic            res_ready;

  assign cfg_ready = 1'b1;

  // Latch the node count on a write beat
  assign nc_nxt = (cfg_valid && cfg_ready) ? cfg_node_count : nc_r;

  // Clamp the node count to the supported range
  assign nc_ext = N_W'(nc_r);
  always_comb begin
    if (nc_ext == '0) begin
      node_n = N_W'(1);
    end else if (nc_ext > N_W'(MAX_NODES)) begin
      node_n = N_W'(MAX_NODES);
    end else begin
      node_n = nc_ext;
    end
  end

  kruskal_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .node_n      (node_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .edge_from   (in_edge_from),
    .edge_to     (in_edge_to),
    .edge_weight (in_edge_weight),
    .last_edge   (in_last_edge),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register loads when empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
      if (res.valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r        <= NC_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      nc_r        <= nc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_edge_taken    = out_r.taken;
  assign out_tree_complete = out_r.complete;
  assign out_tree_weight   = out_r.weight;
  assign out_graph_end     = out_r.graph_end;

endmodule
`default_nettype wire
